[src/dpp_pkg.sv]
// Package for the depth pixel to point block: field widths, register indexes,
// register reset values and the pipeline enable struct. No dependencies.
package dpp_pkg;

  localparam int CoordW = 12;
  localparam int DepthW = 16;
  localparam int ColorW = 8;
  localparam int ScaleW = 32;
  localparam int CenterW = 20;
  localparam int InvW = 24;
  localparam int RangeW = 16;
  localparam int PointW = 24;
  localparam int ZW = 20;
  localparam int ZFullW = DepthW + ScaleW - 12;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_DEPTH_SCALE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTER_X = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_FOCAL_X = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INV_FOCAL_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_RANGE = 3'd5;

  localparam logic [ScaleW-1:0] RST_DEPTH_SCALE = 32'd65536;
  localparam logic [CenterW-1:0] RST_CENTER_X = 20'd80512;
  localparam logic [CenterW-1:0] RST_CENTER_Y = 20'd59215;
  localparam logic [InvW-1:0] RST_INV_FOCAL_X = 24'd27080;
  localparam logic [InvW-1:0] RST_INV_FOCAL_Y = 24'd27092;
  localparam logic [RangeW-1:0] RST_MAX_RANGE = 16'd3000;

  localparam logic [PointW-1:0] POS_LIMIT = 24'd8388607;
  localparam logic [PointW-1:0] NEG_LIMIT = 24'd8388608;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_en_t;

endpackage

[src/dpp_ctl.sv]
// Pipeline control for the depth pixel to point block: stage valid bits,
// per-stage advance enables and the input stall. Uses dpp_pkg.
module dpp_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              drop_s1,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output dpp_pkg::pipe_en_t en
);
  import dpp_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  always_comb begin
    en.en4 = !v4_r || !out_stall;
    en.en3 = !v3_r || en.en4;
    en.en2 = !v2_r || en.en3;
    en.en1 = !v1_r || en.en2;
    v1_nxt = en.en1 ? in_valid : v1_r;
    v2_nxt = en.en2 ? (v1_r && !drop_s1) : v2_r;
    v3_nxt = en.en3 ? v2_r : v3_r;
    v4_nxt = en.en4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_stall = !en.en1;
  assign out_valid = v4_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("input stalled with a bubble in the pipeline");

  a_keep_request: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !drop_s1 && en.en2) |=> v2_r)
    else $error("request lost between stage 1 and stage 2");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en.en3) |=> v3_r)
    else $error("request lost between stage 2 and stage 3");

endmodule

[src/dpp_axis.sv]
// One lateral axis of the back-projection: offset from the optical center,
// scaling by distance and focal reciprocal, rounding and saturation. Uses dpp_pkg.
module dpp_axis (
  input  logic                                  clk,
  input  dpp_pkg::pipe_en_t                     en,
  input  logic [dpp_pkg::CoordW-1:0]            coord,
  input  logic [dpp_pkg::CenterW-1:0]           center_q8,
  input  logic [dpp_pkg::InvW-1:0]              inv_q24,
  input  logic [dpp_pkg::ZW-1:0]                z_s1,
  output logic signed [dpp_pkg::PointW-1:0]     point_q4
);
  import dpp_pkg::*;

  localparam int ProdW = CenterW + ZW;
  localparam int LoW = InvW;
  localparam int HiW = ProdW - LoW;

  logic [CenterW-1:0] pos;
  logic               neg_nxt;
  logic [CenterW-1:0] mag_nxt;
  logic               neg1_r, neg2_r, neg3_r;
  logic [CenterW-1:0] mag1_r;
  logic [ProdW-1:0]   prod2_r;
  logic [LoW+InvW-1:0] lo3_r;
  logic [HiW+InvW-1:0] hi3_r;
  logic [63:0]        sum;
  logic [31:0]        mag;
  logic [PointW-1:0]  sat;
  logic [PointW-1:0]  point_nxt;
  logic [PointW-1:0]  point_r;

  always_comb begin
    pos = {coord, 8'b0};
    neg_nxt = pos < center_q8;
    mag_nxt = neg_nxt ? (center_q8 - pos) : (pos - center_q8);
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      neg1_r <= neg_nxt;
      mag1_r <= mag_nxt;
    end
    if (en.en2) begin
      neg2_r <= neg1_r;
      prod2_r <= ProdW'(mag1_r) * ProdW'(z_s1);
    end
    if (en.en3) begin
      neg3_r <= neg2_r;
      lo3_r <= (LoW+InvW)'(prod2_r[LoW-1:0]) * (LoW+InvW)'(inv_q24);
      hi3_r <= (HiW+InvW)'(prod2_r[ProdW-1:LoW]) * (HiW+InvW)'(inv_q24);
    end
  end

  always_comb begin
    sum = 64'(lo3_r) + {hi3_r, {LoW{1'b0}}} + 64'h0000_0000_8000_0000;
    mag = sum[63:32];
    if (neg3_r) begin
      sat = (mag > 32'(NEG_LIMIT)) ? NEG_LIMIT : mag[PointW-1:0];
      point_nxt = PointW'(0) - sat;
    end else begin
      sat = (mag > 32'(POS_LIMIT)) ? POS_LIMIT : mag[PointW-1:0];
      point_nxt = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en4) begin
      point_r <= point_nxt;
    end
  end

  assign point_q4 = point_r;

endmodule

[src/depth_pixel_to_point.sv]
// Top level of the depth pixel to point block: configuration registers, depth
// scaling, range test and color path. Uses dpp_pkg, dpp_ctl and dpp_axis.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | pixel_row, pixel_col, depth_raw, red_in, green_in, blue_in
//  out     | out_valid/out_stall| point_x_q4, point_y_q4, point_z_q4, red_out, green_out, blue_out
//  cfg     | cfg_we             | cfg_index, cfg_wdata
//
// Four register stages; one request per cycle while the output is not stalled.
// Pixels with zero distance or beyond range are dropped at stage two.
// Reset clears all stage valid bits and loads register defaults.
// A stall at the output holds every full stage; bubbles still close up.
module depth_pixel_to_point #(
  parameter int IMAGE_SIDE_MAX = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dpp_pkg::CoordW-1:0]           in_pixel_row,
  input  logic [dpp_pkg::CoordW-1:0]           in_pixel_col,
  input  logic [dpp_pkg::DepthW-1:0]           in_depth_raw,
  input  logic [dpp_pkg::ColorW-1:0]           in_red_in,
  input  logic [dpp_pkg::ColorW-1:0]           in_green_in,
  input  logic [dpp_pkg::ColorW-1:0]           in_blue_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dpp_pkg::PointW-1:0]    out_point_x_q4,
  output logic signed [dpp_pkg::PointW-1:0]    out_point_y_q4,
  output logic [dpp_pkg::ZW-1:0]               out_point_z_q4,
  output logic [dpp_pkg::ColorW-1:0]           out_red_out,
  output logic [dpp_pkg::ColorW-1:0]           out_green_out,
  output logic [dpp_pkg::ColorW-1:0]           out_blue_out,
  input  logic                                 cfg_we,
  input  logic [dpp_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [dpp_pkg::CfgDataW-1:0]         cfg_wdata
);
  import dpp_pkg::*;

  localparam int SideMax = IMAGE_SIDE_MAX - 1;
  localparam int CoordLimit = (SideMax > 4095) ? 4095 : SideMax;
  localparam logic [CoordW-1:0] CoordMax = CoordW'(CoordLimit);

  logic [ScaleW-1:0]  scale_r;
  logic [CenterW-1:0] cx_r, cy_r;
  logic [InvW-1:0]    ifx_r, ify_r;
  logic [RangeW-1:0]  range_r;

  logic [CoordW-1:0]  row_c, col_c;
  logic [DepthW+ScaleW-1:0] z_prod;
  logic [ZFullW-1:0]  z1_r;
  logic [ZW-1:0]      z2_r, z3_r, z4_r;
  logic [3*ColorW-1:0] rgb1_r, rgb2_r, rgb3_r, rgb4_r;
  logic               drop_s1;
  pipe_en_t           en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= RST_DEPTH_SCALE;
      cx_r <= RST_CENTER_X;
      cy_r <= RST_CENTER_Y;
      ifx_r <= RST_INV_FOCAL_X;
      ify_r <= RST_INV_FOCAL_Y;
      range_r <= RST_MAX_RANGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_SCALE: scale_r <= cfg_wdata;
        REG_CENTER_X:    cx_r <= cfg_wdata[CenterW-1:0];
        REG_CENTER_Y:    cy_r <= cfg_wdata[CenterW-1:0];
        REG_INV_FOCAL_X: ifx_r <= cfg_wdata[InvW-1:0];
        REG_INV_FOCAL_Y: ify_r <= cfg_wdata[InvW-1:0];
        REG_MAX_RANGE:   range_r <= cfg_wdata[RangeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_c = (in_pixel_row > CoordMax) ? CoordMax : in_pixel_row;
    col_c = (in_pixel_col > CoordMax) ? CoordMax : in_pixel_col;
    z_prod = (DepthW+ScaleW)'(in_depth_raw) * (DepthW+ScaleW)'(scale_r);
    drop_s1 = (z1_r == '0) || (z1_r > ZFullW'({range_r, 4'b0}));
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      z1_r <= z_prod[DepthW+ScaleW-1:12];
      rgb1_r <= {in_red_in, in_green_in, in_blue_in};
    end
    if (en.en2) begin
      z2_r <= z1_r[ZW-1:0];
      rgb2_r <= rgb1_r;
    end
    if (en.en3) begin
      z3_r <= z2_r;
      rgb3_r <= rgb2_r;
    end
    if (en.en4) begin
      z4_r <= z3_r;
      rgb4_r <= rgb3_r;
    end
  end

  dpp_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .drop_s1   (drop_s1),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .en        (en)
  );

  dpp_axis u_axis_x (
    .clk       (clk),
    .en        (en),
    .coord     (col_c),
    .center_q8 (cx_r),
    .inv_q24   (ifx_r),
    .z_s1      (z1_r[ZW-1:0]),
    .point_q4  (out_point_x_q4)
  );

  dpp_axis u_axis_y (
    .clk       (clk),
    .en        (en),
    .coord     (row_c),
    .center_q8 (cy_r),
    .inv_q24   (ify_r),
    .z_s1      (z1_r[ZW-1:0]),
    .point_q4  (out_point_y_q4)
  );

  assign out_point_z_q4 = z4_r;
  assign out_red_out = rgb4_r[3*ColorW-1:2*ColorW];
  assign out_green_out = rgb4_r[2*ColorW-1:ColorW];
  assign out_blue_out = rgb4_r[ColorW-1:0];

endmodule

[dv/tb_top.sv]
// Testbench for depth_pixel_to_point: random and directed pixels through the
// back-projection pipe, checked against a local fixed-point predictor.
// Depends on dpp_pkg and the depth_pixel_to_point RTL.
`timescale 1ns / 100ps

module tb_top;
  import dpp_pkg::*;

  localparam int PipeDrain = 8;
  localparam int WatchdogLimit = 3000;
  localparam int SqueezeCycles = 300;
  localparam int MaxReports = 10;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 165;
  localparam int SqueezePhase = 3;

  typedef struct {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [DepthW-1:0] depth;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pixel_t;

  typedef struct {
    logic signed [PointW-1:0] x;
    logic signed [PointW-1:0] y;
    logic [ZW-1:0] z;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } point_t;

  typedef struct {
    bit [ScaleW-1:0] scale;
    bit [CenterW-1:0] cx;
    bit [CenterW-1:0] cy;
    bit [InvW-1:0] ifx;
    bit [InvW-1:0] ify;
    bit [RangeW-1:0] max_mm;
  } camera_cfg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CoordW-1:0] in_pixel_row = '0;
  logic [CoordW-1:0] in_pixel_col = '0;
  logic [DepthW-1:0] in_depth_raw = '0;
  logic [ColorW-1:0] in_red_in = '0;
  logic [ColorW-1:0] in_green_in = '0;
  logic [ColorW-1:0] in_blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PointW-1:0] out_point_x_q4;
  logic signed [PointW-1:0] out_point_y_q4;
  logic [ZW-1:0] out_point_z_q4;
  logic [ColorW-1:0] out_red_out;
  logic [ColorW-1:0] out_green_out;
  logic [ColorW-1:0] out_blue_out;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  pixel_t pixel_q[$];
  point_t point_q[$];
  pixel_t cur_pixel;
  camera_cfg_t cam_cfg;
  int pixels_owed = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int src_wait = 0;
  int sink_wait = 0;
  int squeeze_req = 0;
  int squeeze_seen = 0;
  int quiet_cycles = 0;
  int err_cnt = 0;

  depth_pixel_to_point dut (.*);

  always #6 clk = ~clk;

  function automatic int idle_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PointW-1:0] lateral_q4(input bit [CoordW-1:0] coord,
                                                    input bit [CenterW-1:0] center,
                                                    input bit [InvW-1:0] inv,
                                                    input bit [63:0] z);
    bit [63:0] pos;
    bit [63:0] mag_d;
    bit [63:0] mag;
    bit neg;
    pos = 64'(coord) << 8;
    neg = pos < 64'(center);
    mag_d = neg ? 64'(center) - pos : pos - 64'(center);
    mag = (mag_d * z * 64'(inv) + 64'h8000_0000) >> 32;
    if (neg) begin
      if (mag > 64'(NEG_LIMIT)) mag = 64'(NEG_LIMIT);
      return PointW'(-mag);
    end
    if (mag > 64'(POS_LIMIT)) mag = 64'(POS_LIMIT);
    return PointW'(mag);
  endfunction

  function automatic bit predict_point(input pixel_t px, input camera_cfg_t c,
                                       output point_t pt);
    bit [63:0] z;
    z = (64'(px.depth) * 64'(c.scale)) >> 12;
    pt = '{default: '0};
    if (z == 0 || z > (64'(c.max_mm) << 4)) return 1'b0;
    pt.x = lateral_q4(px.col, c.cx, c.ifx, z);
    pt.y = lateral_q4(px.row, c.cy, c.ify, z);
    pt.z = ZW'(z);
    pt.red = px.red;
    pt.green = px.green;
    pt.blue = px.blue;
    return 1'b1;
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("tb_top: %s", msg);
  endfunction

  function automatic void push_pixel(input int row, input int col, input int depth,
                                     input int red, input int green, input int blue);
    pixel_t px;
    px = '{CoordW'(row), CoordW'(col), DepthW'(depth),
           ColorW'(red), ColorW'(green), ColorW'(blue)};
    pixel_q.insert(pixel_q.size(), px);
    pixels_owed++;
  endfunction

  function automatic void push_random_pixel();
    int pick;
    longint unsigned zt;
    longint unsigned raw;
    pick = $urandom_range(99);
    raw = $urandom_range(16'hFFFF);
    if (pick < 10) begin
      raw = 0;
    end else if (pick < 80 && cam_cfg.scale != 0) begin
      zt = $urandom_range(int'(cam_cfg.max_mm) * 16 + 15);
      raw = (zt << 12) / longint'(cam_cfg.scale);
      if (raw > 16'hFFFF) raw = 16'hFFFF;
    end
    push_pixel($urandom, $urandom, int'(raw), $urandom, $urandom, $urandom);
  endfunction

  function automatic camera_cfg_t rand_camera();
    camera_cfg_t c;
    c.scale = ($urandom_range(9) == 0) ? $urandom : $urandom_range(256, 1 << 20);
    c.cx = CenterW'($urandom);
    c.cy = CenterW'($urandom);
    c.ifx = $urandom_range(1) ? InvW'($urandom) : InvW'($urandom_range(1 << 17));
    c.ify = $urandom_range(1) ? InvW'($urandom) : InvW'($urandom_range(1 << 17));
    c.max_mm = ($urandom_range(7) == 0) ? '1 : RangeW'($urandom_range(1, 65535));
    return c;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEPTH_SCALE: cam_cfg.scale = val;
      REG_CENTER_X: cam_cfg.cx = val[CenterW-1:0];
      REG_CENTER_Y: cam_cfg.cy = val[CenterW-1:0];
      REG_INV_FOCAL_X: cam_cfg.ifx = val[InvW-1:0];
      REG_INV_FOCAL_Y: cam_cfg.ify = val[InvW-1:0];
      REG_MAX_RANGE: cam_cfg.max_mm = val[RangeW-1:0];
      default: ;
    endcase
  endtask

  // upper bits beyond each register are junk and must be dropped
  task automatic load_camera(input camera_cfg_t c);
    write_reg(REG_DEPTH_SCALE, c.scale);
    write_reg(REG_CENTER_X, {12'($urandom), c.cx});
    write_reg(REG_CENTER_Y, {12'($urandom), c.cy});
    write_reg(REG_INV_FOCAL_X, {8'($urandom), c.ifx});
    write_reg(REG_INV_FOCAL_Y, {8'($urandom), c.ify});
    write_reg(REG_MAX_RANGE, {16'($urandom), c.max_mm});
    write_reg(CfgIdxW'(REG_MAX_RANGE + 1 + $urandom_range(1)), $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pixels_owed != 0 || point_q.size() != 0) @(posedge clk);
    repeat (PipeDrain) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_proc
    point_t pt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_point(cur_pixel, cam_cfg, pt)) point_q.insert(point_q.size(), pt);
        pixels_owed--;
      end
      if (!in_valid || !in_stall) begin
        if (src_wait > 0) begin
          src_wait--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          cur_pixel = pixel_q.pop_front();
          in_valid <= 1'b1;
          in_pixel_row <= cur_pixel.row;
          in_pixel_col <= cur_pixel.col;
          in_depth_raw <= cur_pixel.depth;
          in_red_in <= cur_pixel.red;
          in_green_in <= cur_pixel.green;
          in_blue_in <= cur_pixel.blue;
          src_wait = idle_gap(src_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_proc
    int n;
    if (squeeze_req != squeeze_seen) begin
      squeeze_seen = squeeze_req;
      sink_wait = SqueezeCycles;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      out_stall <= 1'b1;
    end else begin
      n = idle_gap(sink_idle_pct);
      out_stall <= (n != 0);
      sink_wait = (n != 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin : check_proc
    point_t want;
    point_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_point_x_q4, out_point_y_q4, out_point_z_q4,
              out_red_out, out_green_out, out_blue_out};
      if (point_q.size() == 0) begin
        note_error($sformatf("unexpected point x=%0d y=%0d z=%0d", got.x, got.y, got.z));
      end else begin
        want = point_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          note_error($sformatf(
            "point mismatch: exp x=%0d y=%0d z=%0d rgb=%h/%h/%h, got x=%0d y=%0d z=%0d rgb=%h/%h/%h",
            want.x, want.y, want.z, want.red, want.green, want.blue,
            got.x, got.y, got.z, got.red, got.green, got.blue));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    camera_cfg_t c;
    cam_cfg = '{RST_DEPTH_SCALE, RST_CENTER_X, RST_CENTER_Y,
                RST_INV_FOCAL_X, RST_INV_FOCAL_Y, RST_MAX_RANGE};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: zero depth, range edge, image corners
    push_pixel(0, 0, 0, 0, 0, 0);
    push_pixel(0, 0, 1, 255, 255, 255);
    push_pixel(4095, 4095, 3000, 255, 0, 255);
    push_pixel(4095, 0, 3001, 1, 2, 3);
    push_pixel(0, 4095, 65535, 9, 9, 9);
    push_pixel(231, 314, 1500, 12, 34, 56);
    push_pixel(2048, 2048, 2000, 8'hAA, 8'h55, 8'hF0);
    settle();

    // saturate X high and Y low
    c = '{scale: 32'd65536, cx: '0, cy: '1, ifx: '1, ify: '1, max_mm: '1};
    load_camera(c);
    push_pixel(0, 4095, 65535, 255, 128, 0);
    push_pixel(4095, 0, 65535, 0, 128, 255);
    push_pixel(0, 0, 1, 77, 88, 99);
    settle();

    // zero focal reciprocals
    c = '{scale: 32'd1 << 20, cx: 20'd524288, cy: 20'd524288, ifx: '0, ify: '0, max_mm: '1};
    load_camera(c);
    push_pixel(100, 3000, 4095, 1, 1, 1);
    push_pixel(4095, 4095, 4096, 2, 2, 2);
    settle();

    // largest scale: every pixel falls outside the range
    c = '{scale: '1, cx: '1, cy: '1, ifx: 24'd1, ify: 24'd1, max_mm: '1};
    load_camera(c);
    push_pixel(1, 1, 1, 3, 3, 3);
    push_pixel(4095, 4095, 65535, 4, 4, 4);
    settle();

    // zero scale, zero range: drop everything
    c = '{scale: '0, cx: '0, cy: '0, ifx: '1, ify: '1, max_mm: '0};
    load_camera(c);
    push_pixel(5, 5, 65535, 5, 5, 5);
    settle();
    write_reg(REG_DEPTH_SCALE, 32'd65536);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_pixel(5, 5, 1, 6, 6, 6);
    settle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      load_camera(rand_camera());
      case (ph % 3)
        0: begin src_idle_pct = 0; sink_idle_pct = 0; end
        1: begin src_idle_pct = 15; sink_idle_pct = 15; end
        default: begin src_idle_pct = 50; sink_idle_pct = 40; end
      endcase
      if (ph == SqueezePhase) begin
        src_idle_pct = 0;
        squeeze_req++;
      end
      repeat (PhaseItems) push_random_pixel();
      settle();
    end

    if (point_q.size() != 0) note_error($sformatf("%0d points never seen", point_q.size()));
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

[sim.f]
src/dpp_pkg.sv
src/dpp_ctl.sv
src/dpp_axis.sv
src/depth_pixel_to_point.sv
dv/tb_top.sv
